### src/shrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample histogram package
// Request codes, configuration register indexes, internal operation kinds
// and the types shared by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package shrt_pkg;

  localparam int unsigned SampleW    = 16;
  localparam int unsigned AddrW      = 10;
  localparam int unsigned CountW     = 32;
  localparam int unsigned ScaleW     = 24;
  localparam int unsigned DiffW      = SampleW + 1;
  localparam int unsigned ProdW      = DiffW + ScaleW + 1;
  localparam int unsigned FracW      = 16;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 24;
  localparam int unsigned QueueDepth = 4;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    REQ_SAMPLE     = 2'd0,
    REQ_READ_CLEAR = 2'd1,
    REQ_RESTART    = 2'd2
  } req_type_e;

  localparam logic [CfgIdxW-1:0] CFG_TRACK_MODE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HINT_MIN   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_HINT_MAX   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BIN_ORIGIN = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BIN_SCALE  = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_BIN,
    OP_TRACK,
    OP_READ,
    OP_READ_MISS,
    OP_RESTART
  } op_kind_e;

  typedef struct packed {
    logic                      track_mode;
    logic signed [SampleW-1:0] hint_min;
    logic signed [SampleW-1:0] hint_max;
    logic signed [SampleW-1:0] bin_origin;
    logic        [ScaleW-1:0]  bin_scale;
  } cfg_t;

  typedef struct packed {
    op_kind_e                  kind;
    logic signed [SampleW-1:0] sample;
    logic        [AddrW-1:0]   bin_address;
    logic                      last_in_batch;
  } op_t;

endpackage

### src/shrt_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one request into the histogram block.
// ----------------------------------------------------------------------------
interface shrt_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [15:0] sample;
  logic [9:0]         bin_address;
  logic               last_in_batch;

  modport source (output valid, output req_type, output sample, output bin_address,
                  output last_in_batch, input ready);
  modport sink   (input valid, input req_type, input sample, input bin_address,
                  input last_in_batch, output ready);
endinterface

### src/shrt_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result out of the histogram block.
// ----------------------------------------------------------------------------
interface shrt_rsp_if;
  logic               valid;
  logic               ready;
  logic [9:0]         bin_idx;
  logic [31:0]        bin_count;
  logic               outlier;
  logic signed [15:0] running_min;
  logic signed [15:0] running_max;
  logic [31:0]        outlier_total;

  modport source (output valid, output bin_idx, output bin_count, output outlier,
                  output running_min, output running_max, output outlier_total,
                  input ready);
  modport sink   (input valid, input bin_idx, input bin_count, input outlier,
                  input running_min, input running_max, input outlier_total,
                  output ready);
endinterface

### src/shrt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram front end
// Accepts requests, computes the scaled bin product and classifies each
// request into an operation for the back end.
// ----------------------------------------------------------------------------
module shrt_front import shrt_pkg::*; #(
  parameter int unsigned BINS  = 1024,
  parameter int unsigned IDX_W = $clog2(BINS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  shrt_req_if.sink         req,
  input  cfg_t             cfg_i,
  input  logic             clr_busy_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output op_t              push_op_o,
  output logic [IDX_W-1:0] push_bin_o
);

  localparam int unsigned HiW = ProdW - FracW;

  logic                      f_valid_q, f_valid_d;
  logic [1:0]                f_req_q;
  logic signed [SampleW-1:0] f_sample_q;
  logic [AddrW-1:0]          f_addr_q;
  logic                      f_last_q;
  logic signed [ProdW-1:0]   f_prod_q, prod_d;
  logic signed [DiffW-1:0]   diff;
  logic signed [ScaleW:0]    scale_s;
  logic [HiW-1:0]            prod_hi;
  logic                      accept;

  assign req.ready = !clr_busy_i && (!f_valid_q || push_ready_i);
  assign accept    = req.valid && req.ready;

  // Exact product of the sample offset and the scale, 16 fraction bits.
  always_comb begin
    diff    = DiffW'(req.sample) - DiffW'(cfg_i.bin_origin);
    scale_s = $signed({1'b0, cfg_i.bin_scale});
    prod_d  = ProdW'(diff) * ProdW'(scale_s);
  end

  assign f_valid_d = accept ? 1'b1 : (push_ready_i ? 1'b0 : f_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_req_q    <= req.req_type;
      f_sample_q <= req.sample;
      f_addr_q   <= req.bin_address;
      f_last_q   <= req.last_in_batch;
      f_prod_q   <= prod_d;
    end
  end

  always_comb begin
    prod_hi                 = HiW'(f_prod_q >>> FracW);
    push_op_o.sample        = f_sample_q;
    push_op_o.bin_address   = f_addr_q;
    push_op_o.last_in_batch = f_last_q;
    push_op_o.kind          = OP_NONE;
    push_bin_o              = '0;
    case (f_req_q)
      REQ_SAMPLE: begin
        if (cfg_i.track_mode) begin
          push_op_o.kind = OP_TRACK;
        end else begin
          push_op_o.kind = OP_BIN;
          // Negative products land in bin zero, large ones in the top bin.
          if (f_prod_q[ProdW-1]) begin
            push_bin_o = '0;
          end else if (prod_hi > HiW'(BINS - 1)) begin
            push_bin_o = IDX_W'(BINS - 1);
          end else begin
            push_bin_o = IDX_W'(prod_hi);
          end
        end
      end
      REQ_READ_CLEAR: begin
        push_bin_o = IDX_W'(f_addr_q);
        if (32'(f_addr_q) < 32'(BINS)) begin
          push_op_o.kind = OP_READ;
        end else begin
          push_op_o.kind = OP_READ_MISS;
        end
      end
      REQ_RESTART: begin
        push_op_o.kind = OP_RESTART;
      end
      default: begin
        push_op_o.kind = OP_NONE;
      end
    endcase
  end

  assign push_valid_o = f_valid_q;

endmodule

### src/shrt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Operation queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module shrt_queue import shrt_pkg::*; #(
  parameter int unsigned IDX_W = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  op_t              push_op_i,
  input  logic [IDX_W-1:0] push_bin_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output op_t              pop_op_o,
  output logic [IDX_W-1:0] pop_bin_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  op_t              op_q  [QueueDepth];
  logic [IDX_W-1:0] bin_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_op_o     = op_q[rd_ptr_q];
  assign pop_bin_o    = bin_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wr_ptr_q]  <= push_op_i;
      bin_q[wr_ptr_q] <= push_bin_i;
    end
  end

endmodule

### src/shrt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram back end
// Holds the bin memory and the range tracking state, carries out one
// operation per cycle while the output register can take a result, with a
// forwarded read-modify-write, and registers the result.
// ----------------------------------------------------------------------------
module shrt_back import shrt_pkg::*; #(
  parameter int unsigned BINS  = 1024,
  parameter int unsigned IDX_W = $clog2(BINS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  output logic             clr_busy_o,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  op_t              pop_op_i,
  input  logic [IDX_W-1:0] pop_bin_i,
  shrt_rsp_if.source       rsp
);

  logic [CountW-1:0] mem [BINS];

  logic              clr_busy_q;
  logic [IDX_W-1:0]  clr_addr_q;

  logic              b_valid_q, b_valid_d;
  op_t               b_op_q;
  logic [IDX_W-1:0]  b_bin_q;
  logic [CountW-1:0] rdata_q;
  logic              b_fire, pop;

  logic              fwd_valid_q;
  logic [IDX_W-1:0]  fwd_addr_q;
  logic [CountW-1:0] fwd_data_q;

  logic signed [SampleW-1:0] cmin_q, cmin_d, cmax_q, cmax_d;
  logic signed [SampleW-1:0] tmin_q, tmin_d, tmax_q, tmax_d;
  logic signed [SampleW-1:0] base_min, base_max;
  logic [CountW-1:0]         ocnt_q, ocnt_d, base_cnt;
  logic                      batch_q, batch_d;

  logic [CountW-1:0] old_cnt, b_wdata;
  logic              b_we;
  logic [AddrW-1:0]  res_idx;
  logic [CountW-1:0] res_cnt;
  logic              res_out;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [CountW-1:0] mem_wdata;

  logic                      out_valid_q, out_valid_d;
  logic [AddrW-1:0]          out_idx_q;
  logic [CountW-1:0]         out_cnt_q;
  logic                      out_out_q;
  logic signed [SampleW-1:0] out_min_q, out_max_q;
  logic [CountW-1:0]         out_total_q;

  assign clr_busy_o  = clr_busy_q;
  assign b_fire      = b_valid_q && (!out_valid_q || rsp.ready);
  assign pop_ready_o = !b_valid_q || b_fire;
  assign pop         = pop_valid_i && pop_ready_o;
  assign b_valid_d   = pop_ready_o ? pop_valid_i : b_valid_q;

  always_comb begin
    // The last write may have gone in after this entry was read.
    old_cnt  = (fwd_valid_q && (fwd_addr_q == b_bin_q)) ? fwd_data_q : rdata_q;
    base_min = batch_q ? cmin_q : tmin_q;
    base_max = batch_q ? cmax_q : tmax_q;
    base_cnt = batch_q ? '0 : ocnt_q;
    b_we     = 1'b0;
    b_wdata  = '0;
    res_idx  = '0;
    res_cnt  = '0;
    res_out  = 1'b0;
    cmin_d   = cmin_q;
    cmax_d   = cmax_q;
    tmin_d   = tmin_q;
    tmax_d   = tmax_q;
    ocnt_d   = ocnt_q;
    batch_d  = batch_q;
    case (b_op_q.kind)
      OP_BIN: begin
        b_we    = 1'b1;
        b_wdata = (old_cnt == CountMax) ? old_cnt : old_cnt + 1'b1;
        res_idx = AddrW'(b_bin_q);
        res_cnt = b_wdata;
      end
      OP_READ: begin
        b_we    = 1'b1;
        res_idx = b_op_q.bin_address;
        res_cnt = old_cnt;
      end
      OP_READ_MISS: begin
        res_idx = b_op_q.bin_address;
      end
      OP_TRACK: begin
        tmin_d  = (b_op_q.sample < base_min) ? b_op_q.sample : base_min;
        tmax_d  = (b_op_q.sample > base_max) ? b_op_q.sample : base_max;
        res_out = (b_op_q.sample < cmin_q) || (b_op_q.sample > cmax_q);
        ocnt_d  = (res_out && (base_cnt != CountMax)) ? base_cnt + 1'b1 : base_cnt;
        batch_d = b_op_q.last_in_batch;
        if (b_op_q.last_in_batch) begin
          cmin_d = tmin_d;
          cmax_d = tmax_d;
        end
      end
      OP_RESTART: begin
        cmin_d  = cfg_i.hint_min;
        cmax_d  = cfg_i.hint_max;
        tmin_d  = cfg_i.hint_min;
        tmax_d  = cfg_i.hint_max;
        ocnt_d  = '0;
        batch_d = 1'b1;
      end
      default: begin
        b_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    mem_we    = clr_busy_q || (b_fire && b_we);
    mem_waddr = clr_busy_q ? clr_addr_q : b_bin_q;
    mem_wdata = clr_busy_q ? '0 : b_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      rdata_q <= mem[pop_bin_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == IDX_W'(BINS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      fwd_valid_q <= 1'b0;
      fwd_addr_q  <= '0;
      fwd_data_q  <= '0;
      cmin_q      <= '0;
      cmax_q      <= '0;
      tmin_q      <= '0;
      tmax_q      <= '0;
      ocnt_q      <= '0;
      batch_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      b_valid_q   <= b_valid_d;
      out_valid_q <= out_valid_d;
      if (b_fire && b_we) begin
        fwd_valid_q <= 1'b1;
        fwd_addr_q  <= b_bin_q;
        fwd_data_q  <= b_wdata;
      end
      if (b_fire) begin
        cmin_q  <= cmin_d;
        cmax_q  <= cmax_d;
        tmin_q  <= tmin_d;
        tmax_q  <= tmax_d;
        ocnt_q  <= ocnt_d;
        batch_q <= batch_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      b_op_q  <= pop_op_i;
      b_bin_q <= pop_bin_i;
    end
    if (b_fire) begin
      out_idx_q   <= res_idx;
      out_cnt_q   <= res_cnt;
      out_out_q   <= res_out;
      out_min_q   <= tmin_d;
      out_max_q   <= tmax_d;
      out_total_q <= ocnt_d;
    end
  end

  assign out_valid_d = b_fire ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_q);

  assign rsp.valid         = out_valid_q;
  assign rsp.bin_idx       = out_idx_q;
  assign rsp.bin_count     = out_cnt_q;
  assign rsp.outlier       = out_out_q;
  assign rsp.running_min   = out_min_q;
  assign rsp.running_max   = out_max_q;
  assign rsp.outlier_total = out_total_q;

endmodule

### src/sample_histogram_with_range_tracking_top.sv
`timescale 1ns / 1ps
// Path: an accepted request passes the front-end register, the queue, the
// back-end operation register and the output register to the result channel.
// Throughput: one request per cycle while results are taken, set by the
// single read-modify-write per cycle on bin memory, last write forwarded.
// Reset: asynchronous and active low; afterwards the bin memory is swept to
// zero, during which no request is accepted.
// ----------------------------------------------------------------------------
// Sample histogram with range tracking
// Calibration helper for fixed-point activations. In binning mode each
// sample is scaled into a bin and that bin's saturating counter is bumped.
// In tracking mode a running minimum and maximum are kept per batch and
// samples outside the committed range are counted as outliers. Software can
// read and clear a bin or restart tracking from a hint range.
// ----------------------------------------------------------------------------
//
// Structure: the front end registers each request together with the exact
// product (sample - origin) * scale, then clamps it to a bin and classifies
// the request. A four-entry queue decouples it from the back end, which
// reads the bin memory when an operation leaves the queue, updates the count
// or the tracking state and writes the result into an output register. The
// output register lets the back end take the next operation while a
// finished result still waits on the result channel.
//
// Configuration registers live here and are written through a plain write
// port; indexes that do not name a register are ignored. They are expected
// to change only while no request is in flight.
module sample_histogram_with_range_tracking_top import shrt_pkg::*; #(
  parameter int unsigned BINS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  shrt_req_if.sink            req_i,
  shrt_rsp_if.source          rsp_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = $clog2(BINS);

  cfg_t             cfg_q;
  logic             clr_busy;
  logic             push_valid, push_ready;
  op_t              push_op;
  logic [IdxW-1:0]  push_bin;
  logic             pop_valid, pop_ready;
  op_t              pop_op;
  logic [IdxW-1:0]  pop_bin;

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TRACK_MODE: cfg_q.track_mode <= cfg_data_i[0];
        CFG_HINT_MIN:   cfg_q.hint_min   <= cfg_data_i[SampleW-1:0];
        CFG_HINT_MAX:   cfg_q.hint_max   <= cfg_data_i[SampleW-1:0];
        CFG_BIN_ORIGIN: cfg_q.bin_origin <= cfg_data_i[SampleW-1:0];
        CFG_BIN_SCALE:  cfg_q.bin_scale  <= cfg_data_i[ScaleW-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  shrt_front #(
    .BINS  (BINS),
    .IDX_W (IdxW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_i),
    .cfg_i        (cfg_q),
    .clr_busy_i   (clr_busy),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_op_o    (push_op),
    .push_bin_o   (push_bin)
  );

  shrt_queue #(
    .IDX_W (IdxW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_op_i    (push_op),
    .push_bin_i   (push_bin),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_op_o     (pop_op),
    .pop_bin_o    (pop_bin)
  );

  shrt_back #(
    .BINS  (BINS),
    .IDX_W (IdxW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .clr_busy_o  (clr_busy),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_op_i    (pop_op),
    .pop_bin_i   (pop_bin),
    .rsp         (rsp_o)
  );

endmodule
